// ===== sv/mkr_pkg.sv =====
// Shared types and constants for the motor kick/run duty sequencer.
package mkr_pkg;

    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned START_W  = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned PROD_W   = 18;
    localparam int unsigned RECIP_W  = 36;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd50;
    localparam logic [START_W-1:0]  START_RESET  = 16'd250;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_START  = 1'b1;

    localparam logic REQ_RUN  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [7:0]  CHECK_SUM   = 8'hFF;
    localparam logic [7:0]  SEC_MIN     = 8'd1;
    localparam logic [7:0]  SEC_MAX     = 8'd60;
    localparam logic [7:0]  DUTY_MIN    = 8'd1;
    localparam logic [7:0]  DUTY_MAX    = 8'd100;
    localparam logic [17:0] MS_PER_SEC  = 18'd1000;
    // ceil(2^24 / 100): floor(p / 100) for p up to 1023 * 100
    localparam logic [RECIP_W-1:0] RECIP_100 = 36'd167773;
    localparam int unsigned RECIP_SHIFT = 24;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2,
        ST_TICK    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_KICK = 2'd1,
        PH_RUN  = 2'd2
    } t_phase;

    typedef struct packed {
        logic                req_tick;
        logic                ok;
        logic [START_W-1:0]  total_ms;
        logic [PERIOD_W-1:0] on_ms;
    } t_cmd;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ms;
        logic [START_W-1:0]  start_ms;
    } t_cfg;

endpackage

// ===== sv/mkr_front.sv =====
// Front end: accepts items, checks requests and computes the run on-time.
module mkr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [7:0]           i_run_seconds,
    input  logic [7:0]           i_duty_percent,
    input  logic [7:0]           i_check_byte,
    input  mkr_pkg::t_cfg        i_cfg,
    output logic                 o_push,
    output mkr_pkg::t_cmd        o_cmd,
    input  logic                 i_q_ready
);
    import mkr_pkg::*;

    logic                r_s1_valid;
    logic                n_s1_valid;
    logic                r_s1_tick;
    logic                r_s1_ok;
    logic [START_W-1:0]  r_s1_total;
    logic [PROD_W-1:0]   r_s1_prod;

    logic                w_take;
    logic [7:0]          w_sum;
    logic                w_ok;
    logic [17:0]         w_total;
    logic [RECIP_W-1:0]  w_recip;

    assign o_stall = r_s1_valid && !i_q_ready;
    assign w_take  = i_valid && !o_stall;
    assign o_push  = r_s1_valid && i_q_ready;

    assign w_sum   = i_run_seconds + i_duty_percent + i_check_byte;
    assign w_ok    = (w_sum == CHECK_SUM)
                  && (i_run_seconds >= SEC_MIN) && (i_run_seconds <= SEC_MAX)
                  && (i_duty_percent >= DUTY_MIN) && (i_duty_percent <= DUTY_MAX);
    assign w_total = {10'd0, i_run_seconds} * MS_PER_SEC;
    assign w_recip = {{(RECIP_W-PROD_W){1'b0}}, r_s1_prod} * RECIP_100;

    always_comb begin
        if (w_take) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_tick  <= (i_req_type == REQ_TICK);
            r_s1_ok    <= w_ok;
            r_s1_total <= w_total[START_W-1:0];
            r_s1_prod  <= {{(PROD_W-PERIOD_W){1'b0}}, i_cfg.period_ms}
                          * {{(PROD_W-8){1'b0}}, i_duty_percent};
        end
    end

    always_comb begin
        o_cmd.req_tick = r_s1_tick;
        o_cmd.ok       = r_s1_ok;
        o_cmd.total_ms = r_s1_total;
        o_cmd.on_ms    = w_recip[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];
    end

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("front stalls with an empty stage");

endmodule

// ===== sv/mkr_queue.sv =====
// Short command queue between the front end and the sequencer.
module mkr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mkr_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_not_empty,
    output mkr_pkg::t_cmd o_cmd
);
    import mkr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready     = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign w_push      = i_push && o_ready;
    assign w_pop       = i_pop && o_not_empty;
    assign o_cmd       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ===== sv/mkr_back.sv =====
// Back end: kick/run phase sequencer with registered result.
module mkr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_not_empty,
    input  mkr_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    input  mkr_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [mkr_pkg::PERIOD_W-1:0]      o_duty_on_ms,
    output logic                              o_running
);
    import mkr_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [START_W-1:0]  r_remaining;
    logic [START_W-1:0]  n_remaining;
    logic [START_W-1:0]  r_run_ms;
    logic [START_W-1:0]  n_run_ms;
    logic [PERIOD_W-1:0] r_run_on;
    logic [PERIOD_W-1:0] n_run_on;
    t_status             n_status;
    logic [PERIOD_W-1:0] n_duty;
    logic                n_running;

    logic                r_out_valid;
    t_status             r_status;
    logic [PERIOD_W-1:0] r_duty;
    logic                r_running;

    logic                w_busy;
    logic [START_W-1:0]  w_new_run;
    logic [START_W-1:0]  w_rem_dec;

    assign o_pop     = i_not_empty && (!r_out_valid || !i_stall);
    assign w_busy    = (r_phase == PH_KICK) || (r_phase == PH_RUN);
    assign w_new_run = (i_cmd.total_ms > i_cfg.start_ms)
                     ? i_cmd.total_ms - i_cfg.start_ms : '0;
    assign w_rem_dec = (r_remaining != '0) ? r_remaining - 1'b1 : r_remaining;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_run_ms    = r_run_ms;
        n_run_on    = r_run_on;
        n_status    = ST_TICK;
        if (i_cmd.req_tick) begin
            case (r_phase)
                PH_KICK: begin
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        n_phase     = (r_run_ms == '0) ? PH_IDLE : PH_RUN;
                        n_remaining = r_run_ms;
                    end
                end
                PH_RUN: begin
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (!i_cmd.ok) begin
            n_status = ST_INVALID;
        end else if (w_busy) begin
            n_status = ST_BUSY;
        end else begin
            n_status = ST_ACCEPT;
            n_run_on = i_cmd.on_ms;
            n_run_ms = w_new_run;
            if (i_cfg.start_ms == '0) begin
                n_phase     = (w_new_run == '0) ? PH_IDLE : PH_RUN;
                n_remaining = w_new_run;
            end else begin
                n_phase     = PH_KICK;
                n_remaining = i_cfg.start_ms;
            end
        end
    end

    // result fields
    always_comb begin
        case (n_phase)
            PH_KICK: begin
                n_duty    = i_cfg.period_ms;
                n_running = 1'b1;
            end
            PH_RUN: begin
                n_duty    = n_run_on;
                n_running = 1'b1;
            end
            default: begin
                n_duty    = '0;
                n_running = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_remaining <= '0;
            r_run_ms    <= '0;
            r_run_on    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_run_ms    <= n_run_ms;
                r_run_on    <= n_run_on;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_duty    <= n_duty;
            r_running <= n_running;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_duty_on_ms = r_duty;
    assign o_running    = r_running;

    a_busy_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_status == ST_BUSY) |=> $stable(r_phase) && $stable(r_remaining))
        else $error("busy refusal changed sequencer state");

    a_idle_drives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_running) |-> (r_duty == '0))
        else $error("nonzero duty while not running");

    a_running_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(o_pop)) |-> (r_running == w_busy))
        else $error("running flag disagrees with phase");

endmodule

// ===== sv/motor_kick_run_duty_sequencer.sv =====
// Top level of the motor kick/run duty sequencer.
//
//   channel   valid     stall     payload
//   request   i_valid   o_stall   i_req_type, i_run_seconds, i_duty_percent, i_check_byte
//   result    o_valid   i_stall   o_status, o_duty_on_ms, o_running
//   config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while no stall holds the flow. Each result passes
// the check stage register, a divide by 100 on the way into the queue, the queue
// and the sequencer output register. Reset is synchronous and clears the sequencer
// to idle and the registers to period 50 ms and kick 250 ms. A stalled result holds;
// the queue of QUEUE_DEPTH entries and the check stage absorb input until full.
module motor_kick_run_duty_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_run_seconds,
    input  logic [7:0]                    i_duty_percent,
    input  logic [7:0]                    i_check_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [mkr_pkg::PERIOD_W-1:0]  o_duty_on_ms,
    output logic                          o_running,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [mkr_pkg::CFG_W-1:0]     i_cfg_data
);
    import mkr_pkg::*;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_push;
    logic w_q_ready;
    logic w_pop;
    logic w_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ms <= PERIOD_RESET;
            r_cfg.start_ms  <= START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: r_cfg.period_ms <= i_cfg_data[PERIOD_W-1:0];
                CFG_START:  r_cfg.start_ms  <= i_cfg_data[START_W-1:0];
                default:    r_cfg           <= r_cfg;
            endcase
        end
    end

    mkr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_run_seconds  (i_run_seconds),
        .i_duty_percent (i_duty_percent),
        .i_check_byte   (i_check_byte),
        .i_cfg          (r_cfg),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd),
        .i_q_ready      (w_q_ready)
    );

    mkr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_cmd       (w_front_cmd),
        .o_ready     (w_q_ready),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_q_cmd)
    );

    mkr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_not_empty  (w_not_empty),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_duty_on_ms (o_duty_on_ms),
        .o_running    (o_running)
    );

endmodule
